### rtl/cpcr_pkg.sv
package cpcr_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int CFG_DATA_W = 31;
	localparam logic [30:0] CONTACT_SLOP_RST = 31'd655;
	localparam logic [15:0] MIN_SEPARATION_RST = 16'd0;

	typedef enum logic [0:0] {
		CFG_CONTACT_SLOP   = 1'b0,
		CFG_MIN_SEPARATION = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] a_vx;
		logic signed [31:0] a_vy;
		logic signed [31:0] b_vx;
		logic signed [31:0] b_vy;
		logic [30:0] a_inv_mass;
		logic [30:0] b_inv_mass;
		logic [30:0] a_radius;
		logic [30:0] b_radius;
	} pair_t;

	typedef struct packed {
		logic signed [31:0] out_a_x;
		logic signed [31:0] out_a_y;
		logic signed [31:0] out_b_x;
		logic signed [31:0] out_b_y;
		logic signed [31:0] out_a_vx;
		logic signed [31:0] out_a_vy;
		logic signed [31:0] out_b_vx;
		logic signed [31:0] out_b_vy;
		logic in_contact;
		logic velocity_changed;
	} result_t;

endpackage

### rtl/circle_pair_contact_resolver.sv
// Resolves one pair of circular particles per beat: overlap test, contact normal, positional
// push-apart shared by inverse mass, and an elastic impulse when the pair approaches. A new
// pair can be taken every cycle while the result side is ready or a stage holds a bubble;
// the pipeline holds the 32-stage bit-per-stage square root of the squared distance and
// the FRACTION_BITS + 1 stage restoring dividers for the normal and the mass shares,
// followed by multiply stages for correction and impulse. Stalls on the result side back
// up only as far as the pipeline is full, so bubbles are squeezed out.
module circle_pair_contact_resolver #(
	parameter int FRACTION_BITS = cpcr_pkg::FRACTION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pair_valid,
	output logic                              pair_ready,
	input  cpcr_pkg::pair_t                   pair,
	output logic                              result_valid,
	input  logic                              result_ready,
	output cpcr_pkg::result_t                 result,
	input  logic                              cfg_we,
	input  cpcr_pkg::cfg_reg_t                cfg_index,
	input  logic [cpcr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	localparam int F = FRACTION_BITS;
	localparam int SQ_BITS = 32;
	localparam int ST_SQ0 = 4;
	localparam int ST_P = ST_SQ0 + SQ_BITS;
	localparam int ST_DV0 = ST_P + 1;
	localparam int ST_N0 = ST_DV0 + F + 1;
	localparam int ST_M1 = ST_N0 + 1;
	localparam int ST_M2 = ST_N0 + 2;
	localparam int ST_M3 = ST_N0 + 3;
	localparam int ST_M4 = ST_N0 + 4;
	localparam int ST_M5 = ST_N0 + 5;
	localparam int NS = ST_N0 + 6;
	localparam int RXW = F + 32;
	localparam int RAW = F + 31;
	localparam int DXW = F + 33;
	localparam int NW = F + 2;
	localparam int PW = F + 35;
	localparam int JW = F + 37;
	localparam int WW = F + 39;

	typedef struct packed {
		cpcr_pkg::pair_t     p;
		logic signed [32:0]  dx;
		logic signed [32:0]  dy;
		logic [31:0]         ux;
		logic [31:0]         uy;
		logic [31:0]         cr;
		logic [31:0]         isum;
		logic                ok;
		logic [63:0]         sqx;
		logic [63:0]         sqy;
		logic [63:0]         crsq;
		logic [63:0]         rem;
		logic [31:0]         root;
		logic                hit;
		logic                deflt;
		logic [31:0]         dlen;
		logic [31:0]         depth;
		logic [RXW-1:0]      nrx;
		logic [RXW-1:0]      nry;
		logic [RAW-1:0]      nra;
		logic [RAW-1:0]      nrb;
		logic [F:0]          qx;
		logic [F:0]          qy;
		logic [F:0]          qa;
		logic [F:0]          qb;
		logic signed [NW-1:0] nx;
		logic signed [NW-1:0] ny;
		logic signed [32:0]  rvx;
		logic signed [32:0]  rvy;
		logic signed [PW-1:0] px;
		logic signed [PW-1:0] py;
		logic signed [PW-1:0] pvx;
		logic signed [PW-1:0] pvy;
		logic signed [32:0]  sx;
		logic signed [32:0]  sy;
		logic                vchg;
		logic [35:0]         j;
		logic signed [PW-1:0] pax;
		logic signed [PW-1:0] pay;
		logic signed [PW-1:0] pbx;
		logic signed [PW-1:0] pby;
		logic [JW-1:0]       pja;
		logic [JW-1:0]       pjb;
		logic [35:0]         ja;
		logic [35:0]         jb;
		logic signed [WW-1:0] wax;
		logic signed [WW-1:0] way;
		logic signed [WW-1:0] wbx;
		logic signed [WW-1:0] wby;
		cpcr_pkg::result_t   res;
	} pipe_t;

	function automatic logic signed [79:0] tdiv(input logic signed [79:0] v);
		logic signed [79:0] bias;
		bias = v[79] ? ((80'sd1 <<< F) - 80'sd1) : 80'sd0;
		return (v + bias) >>> F;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
		logic signed [31:0] r;
		if (v > 80'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -80'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	logic [30:0] slop_q;
	logic [15:0] min_sep_q;
	logic [NS:1] v_s;
	logic [NS:1] v_in;
	logic [NS:1] ld;
	pipe_t       pipe_s [1:NS];
	pipe_t       nxt [1:NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slop_q <= cpcr_pkg::CONTACT_SLOP_RST;
			min_sep_q <= cpcr_pkg::MIN_SEPARATION_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cpcr_pkg::CFG_CONTACT_SLOP: slop_q <= cfg_wdata;
				cpcr_pkg::CFG_MIN_SEPARATION: min_sep_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// a stage loads when the result side is ready or when it or any stage after it holds a bubble
	for (genvar g = 1; g <= NS; g++) begin : g_ld
		assign ld[g] = result_ready || !(&v_s[NS:g]);
	end

	assign v_in = {v_s[NS-1:1], pair_valid};
	assign pair_ready = ld[1];
	assign result_valid = v_s[NS];
	assign result = pipe_s[NS].res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int i = 1; i <= NS; i++) begin
				if (ld[i]) begin
					v_s[i] <= v_in[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 1; i <= NS; i++) begin
			if (ld[i]) begin
				pipe_s[i] <= nxt[i];
			end
		end
	end

	// differences, magnitudes, early rejects
	always_comb begin
		pipe_t s;
		s = '0;
		s.p = pair;
		s.dx = 33'(pair.b_x) - 33'(pair.a_x);
		s.dy = 33'(pair.b_y) - 33'(pair.a_y);
		s.ux = s.dx[32] ? 32'(-s.dx) : s.dx[31:0];
		s.uy = s.dy[32] ? 32'(-s.dy) : s.dy[31:0];
		s.cr = 32'(pair.a_radius) + 32'(pair.b_radius);
		s.isum = 32'(pair.a_inv_mass) + 32'(pair.b_inv_mass);
		s.ok = (s.isum != '0) && (s.cr != '0) && (s.ux < s.cr) && (s.uy < s.cr);
		nxt[1] = s;
	end

	always_comb begin
		pipe_t s;
		s = pipe_s[1];
		s.sqx = {32'b0, s.ux} * {32'b0, s.ux};
		s.sqy = {32'b0, s.uy} * {32'b0, s.uy};
		s.crsq = {32'b0, s.cr} * {32'b0, s.cr};
		nxt[2] = s;
	end

	always_comb begin
		pipe_t s;
		logic [64:0] sum;
		s = pipe_s[2];
		sum = {1'b0, s.sqx} + {1'b0, s.sqy};
		s.hit = s.ok && !sum[64] && (sum[63:0] < s.crsq);
		s.rem = sum[63:0];
		s.root = '0;
		nxt[3] = s;
	end

	// square root, one result bit per stage
	for (genvar g = ST_SQ0; g < ST_P; g++) begin : g_sqrt
		localparam int K = ST_P - 1 - g;
		always_comb begin
			pipe_t s;
			logic [65:0] t;
			s = pipe_s[g-1];
			t = ({34'b0, s.root} << (K + 1)) + (66'd1 << (2 * K));
			if ({2'b0, s.rem} >= t) begin
				s.rem = s.rem - t[63:0];
				s.root[K] = 1'b1;
			end
			nxt[g] = s;
		end
	end

	always_comb begin
		pipe_t s;
		logic [31:0] pen;
		s = pipe_s[ST_P-1];
		s.deflt = s.root <= {16'b0, min_sep_q};
		s.dlen = s.deflt ? '0 : s.root;
		pen = s.cr - s.dlen;
		s.depth = (pen > {1'b0, slop_q}) ? pen - {1'b0, slop_q} : '0;
		s.nrx = RXW'(s.ux) << F;
		s.nry = RXW'(s.uy) << F;
		s.nra = RAW'(s.p.a_inv_mass) << F;
		s.nrb = RAW'(s.p.b_inv_mass) << F;
		s.qx = '0;
		s.qy = '0;
		s.qa = '0;
		s.qb = '0;
		nxt[ST_P] = s;
	end

	// restoring dividers for the normal and the two mass shares
	for (genvar g = ST_DV0; g < ST_N0; g++) begin : g_div
		localparam int K = ST_N0 - 1 - g;
		always_comb begin
			pipe_t s;
			logic [DXW-1:0] dd;
			logic [DXW-1:0] ds;
			s = pipe_s[g-1];
			dd = DXW'(s.dlen) << K;
			ds = DXW'(s.isum) << K;
			if (DXW'(s.nrx) >= dd) begin
				s.nrx = s.nrx - dd[RXW-1:0];
				s.qx[K] = 1'b1;
			end
			if (DXW'(s.nry) >= dd) begin
				s.nry = s.nry - dd[RXW-1:0];
				s.qy[K] = 1'b1;
			end
			if (DXW'(s.nra) >= ds) begin
				s.nra = s.nra - ds[RAW-1:0];
				s.qa[K] = 1'b1;
			end
			if (DXW'(s.nrb) >= ds) begin
				s.nrb = s.nrb - ds[RAW-1:0];
				s.qb[K] = 1'b1;
			end
			nxt[g] = s;
		end
	end

	always_comb begin
		pipe_t s;
		logic signed [NW-1:0] mx;
		logic signed [NW-1:0] my;
		s = pipe_s[ST_N0-1];
		mx = NW'({1'b0, s.qx});
		my = NW'({1'b0, s.qy});
		if (s.deflt) begin
			s.nx = NW'(1) <<< F;
			s.ny = '0;
		end else begin
			s.nx = s.dx[32] ? -mx : mx;
			s.ny = s.dy[32] ? -my : my;
		end
		s.rvx = 33'(s.p.b_vx) - 33'(s.p.a_vx);
		s.rvy = 33'(s.p.b_vy) - 33'(s.p.a_vy);
		nxt[ST_N0] = s;
	end

	always_comb begin
		pipe_t s;
		logic signed [32:0] dep;
		s = pipe_s[ST_N0];
		dep = {1'b0, s.depth};
		s.px = PW'(dep) * PW'(s.nx);
		s.py = PW'(dep) * PW'(s.ny);
		s.pvx = PW'(s.rvx) * PW'(s.nx);
		s.pvy = PW'(s.rvy) * PW'(s.ny);
		nxt[ST_M1] = s;
	end

	always_comb begin
		pipe_t s;
		logic signed [PW:0] vsum;
		logic signed [34:0] vn;
		logic signed [35:0] jt;
		s = pipe_s[ST_M1];
		s.sx = 33'(tdiv(80'(s.px)));
		s.sy = 33'(tdiv(80'(s.py)));
		vsum = (PW+1)'(s.pvx) + (PW+1)'(s.pvy);
		vn = 35'(tdiv(80'(vsum)));
		s.vchg = s.hit && vn[34];
		jt = -(36'(vn) <<< 1);
		s.j = jt;
		nxt[ST_M2] = s;
	end

	always_comb begin
		pipe_t s;
		logic signed [NW-1:0] fas;
		logic signed [NW-1:0] fbs;
		s = pipe_s[ST_M2];
		fas = {1'b0, s.qa};
		fbs = {1'b0, s.qb};
		s.pax = PW'(s.sx) * PW'(fas);
		s.pay = PW'(s.sy) * PW'(fas);
		s.pbx = PW'(s.sx) * PW'(fbs);
		s.pby = PW'(s.sy) * PW'(fbs);
		s.pja = JW'(s.j) * JW'(s.qa);
		s.pjb = JW'(s.j) * JW'(s.qb);
		nxt[ST_M3] = s;
	end

	always_comb begin
		pipe_t s;
		s = pipe_s[ST_M3];
		if (s.hit) begin
			s.res.out_a_x = sat32(80'(s.p.a_x) - tdiv(80'(s.pax)));
			s.res.out_a_y = sat32(80'(s.p.a_y) - tdiv(80'(s.pay)));
			s.res.out_b_x = sat32(80'(s.p.b_x) + tdiv(80'(s.pbx)));
			s.res.out_b_y = sat32(80'(s.p.b_y) + tdiv(80'(s.pby)));
		end else begin
			s.res.out_a_x = s.p.a_x;
			s.res.out_a_y = s.p.a_y;
			s.res.out_b_x = s.p.b_x;
			s.res.out_b_y = s.p.b_y;
		end
		s.res.in_contact = s.hit;
		s.ja = 36'(s.pja >> F);
		s.jb = 36'(s.pjb >> F);
		nxt[ST_M4] = s;
	end

	always_comb begin
		pipe_t s;
		logic signed [36:0] jas;
		logic signed [36:0] jbs;
		s = pipe_s[ST_M4];
		jas = {1'b0, s.ja};
		jbs = {1'b0, s.jb};
		s.wax = WW'(jas) * WW'(s.nx);
		s.way = WW'(jas) * WW'(s.ny);
		s.wbx = WW'(jbs) * WW'(s.nx);
		s.wby = WW'(jbs) * WW'(s.ny);
		nxt[ST_M5] = s;
	end

	always_comb begin
		pipe_t s;
		s = pipe_s[ST_M5];
		if (s.vchg) begin
			s.res.out_a_vx = sat32(80'(s.p.a_vx) - tdiv(80'(s.wax)));
			s.res.out_a_vy = sat32(80'(s.p.a_vy) - tdiv(80'(s.way)));
			s.res.out_b_vx = sat32(80'(s.p.b_vx) + tdiv(80'(s.wbx)));
			s.res.out_b_vy = sat32(80'(s.p.b_vy) + tdiv(80'(s.wby)));
		end else begin
			s.res.out_a_vx = s.p.a_vx;
			s.res.out_a_vy = s.p.a_vy;
			s.res.out_b_vx = s.p.b_vx;
			s.res.out_b_vy = s.p.b_vy;
		end
		s.res.velocity_changed = s.vchg;
		nxt[NS] = s;
	end

endmodule

### rtl/cpcr_checker.sv
module cpcr_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              pair_valid,
	input logic              pair_ready,
	input logic              result_valid,
	input logic              result_ready,
	input cpcr_pkg::result_t result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_impulse_needs_contact: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.velocity_changed |-> result.in_contact)
		else $error("impulse without contact");

	a_ready_follows_sink: assert property (@(posedge clk) disable iff (!arst_n)
		result_ready |-> pair_ready)
		else $error("input blocked while result side is ready");

	a_block_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pair_ready |-> result_valid && !result_ready)
		else $error("input blocked without a stalled result");

endmodule

bind circle_pair_contact_resolver cpcr_checker u_cpcr_checker (.*);
